@@ sv/mouse_aim_subpixel_accumulator_macros.svh @@
`ifndef MOUSE_AIM_SUBPIXEL_ACCUMULATOR_MACROS_SVH
`define MOUSE_AIM_SUBPIXEL_ACCUMULATOR_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define MASA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define MASA_ASSERT_NEVER(label, expr, msg) \
  `MASA_ASSERT(label, !(expr), msg)

`endif

@@ sv/masa_pkg.sv @@
`timescale 1ns / 1ps

package masa_pkg;

  localparam int DELTA_W  = 16;
  localparam int GAIN_W   = 24;
  localparam int LEVEL_W  = 31;
  localparam int CFG_W    = 31;
  localparam int IDX_W    = 3;
  localparam int RES_W    = 32;
  localparam int PROD_W   = DELTA_W + GAIN_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int STEP_W   = 16;

  localparam int RES_LIMIT    = 1073741824;
  localparam int DIRECT_SHIFT = 12;
  localparam int FRAC_SHIFT   = 14;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(RES_LIMIT);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;
  localparam logic signed [RES_W-1:0] RES_HI = RES_W'(RES_LIMIT);
  localparam logic signed [RES_W-1:0] RES_LO = -RES_HI;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

  typedef enum logic [IDX_W-1:0] {
    CFG_GAIN_X   = 3'd0,
    CFG_GAIN_Y   = 3'd1,
    CFG_DEADZONE = 3'd2,
    CFG_SNAP     = 3'd3,
    CFG_DIRECT   = 3'd4,
    CFG_HOOK     = 3'd5,
    CFG_CARRY    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_MEM  = 2'd1,
    DEST_HOOK = 2'd2
  } dest_e;

  typedef struct packed {
    logic sat;
    logic clear;
    logic take_step;
  } lane_ctl_t;

  typedef struct packed {
    logic                     res_zero;
    logic                     below_dz;
    logic                     step_nz;
    logic signed [STEP_W-1:0] step;
  } lane_info_t;

endpackage

@@ sv/masa_lane.sv @@
`timescale 1ns / 1ps

module masa_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic                                  commit_i,
  input  logic signed [masa_pkg::DELTA_W-1:0]   delta_i,
  input  logic        [masa_pkg::GAIN_W-1:0]    gain_i,
  input  logic                                  direct_i,
  input  logic        [masa_pkg::LEVEL_W-1:0]   deadzone_i,
  input  logic        [masa_pkg::LEVEL_W-1:0]   snap_i,
  input  masa_pkg::lane_ctl_t                   ctl_i,
  output masa_pkg::lane_info_t                  info_o
);

  logic signed [masa_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [masa_pkg::RES_W-1:0]  residual_d, residual_q;
  logic signed [masa_pkg::SUM_W-1:0]  sum;
  logic signed [masa_pkg::RES_W-1:0]  rs, rn, dir_q, leg_q, sub_val;
  logic        [masa_pkg::RES_W-1:0]  mag;
  logic                               at_snap, below_dz;
  logic signed [masa_pkg::STEP_W-1:0] step_leg, step;

  assign prod_d = masa_pkg::PROD_W'(delta_i) * masa_pkg::PROD_W'($signed({1'b0, gain_i}));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum = masa_pkg::SUM_W'(residual_q) + masa_pkg::SUM_W'(prod_q);
    if (!ctl_i.sat) begin
      rs = residual_q;
    end else if (sum > masa_pkg::SUM_HI) begin
      rs = masa_pkg::RES_HI;
    end else if (sum < masa_pkg::SUM_LO) begin
      rs = masa_pkg::RES_LO;
    end else begin
      rs = sum[masa_pkg::RES_W-1:0];
    end

    mag      = rs[masa_pkg::RES_W-1] ? -rs : rs;
    below_dz = mag < {1'b0, deadzone_i};
    at_snap  = mag >= {1'b0, snap_i};

    dir_q = rs >>> masa_pkg::DIRECT_SHIFT;
    leg_q = rs >>> masa_pkg::FRAC_SHIFT;

    if (at_snap) begin
      step_leg = leg_q[masa_pkg::STEP_W-1:0];
    end else if (!below_dz) begin
      step_leg = rs[masa_pkg::RES_W-1] ? -16'sd1 : 16'sd1;
    end else begin
      step_leg = '0;
    end

    step = direct_i ? dir_q[masa_pkg::STEP_W-1:0] : step_leg;

    if (direct_i) begin
      sub_val = masa_pkg::RES_W'(step) <<< masa_pkg::DIRECT_SHIFT;
    end else begin
      sub_val = masa_pkg::RES_W'(step) <<< masa_pkg::FRAC_SHIFT;
    end
    rn = rs - sub_val;

    if (ctl_i.clear) begin
      residual_d = '0;
    end else if (ctl_i.take_step) begin
      residual_d = rn;
    end else begin
      residual_d = rs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residual_q <= '0;
    end else if (commit_i) begin
      residual_q <= residual_d;
    end
  end

  assign info_o.res_zero = (residual_q == '0);
  assign info_o.below_dz = below_dz;
  assign info_o.step_nz  = (step != '0);
  assign info_o.step     = step;

endmodule

@@ sv/mouse_aim_subpixel_accumulator.sv @@
`timescale 1ns / 1ps

// Sub-pixel mouse aim accumulator with one lane per axis. A poll enters every
// cycle unless the output is back-pressured; its result passes the product stage,
// then the residual update into the output register. The per-axis residual feedback
// (add product, saturate, pick step, subtract consumed part) is a single
// combinational path that sets the clock. Each accepted poll gives exactly
// one result transaction; destination none carries zero steps.
`include "mouse_aim_subpixel_accumulator_macros.svh"

module mouse_aim_subpixel_accumulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [31:0]                       s_axis_tdata_i,  // delta_x, delta_y
  input  logic [1:0]                        s_axis_tuser_i,  // suspend, focused
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,  // aim_x, aim_y
  output logic [1:0]                        m_axis_tuser_o,  // destination
  input  logic                              cfg_we_i,
  input  logic [masa_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [masa_pkg::CFG_W-1:0]        cfg_wdata_i
);

  logic [masa_pkg::GAIN_W-1:0]  gain_x_q, gain_y_q;
  logic [masa_pkg::LEVEL_W-1:0] deadzone_q, snap_q;
  logic                         direct_q, hook_q, carry_q;

  logic                         s1_valid_q, s1_blocked_q, s1_has_delta_q;
  logic                         in_accept, adv2;

  logic                         m_valid_q;
  logic [masa_pkg::STEP_W-1:0]  aim_x_d, aim_x_q, aim_y_d, aim_y_q;
  masa_pkg::dest_e              dest_d, dest_q;

  logic                         idle, dz_hold, emit;
  masa_pkg::lane_ctl_t          ctl;
  masa_pkg::lane_info_t         info_x, info_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q   <= masa_pkg::GAIN_RESET;
      gain_y_q   <= masa_pkg::GAIN_RESET;
      deadzone_q <= '0;
      snap_q     <= '0;
      direct_q   <= 1'b0;
      hook_q     <= 1'b0;
      carry_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (masa_pkg::cfg_reg_e'(cfg_idx_i))
        masa_pkg::CFG_GAIN_X:   gain_x_q   <= cfg_wdata_i[masa_pkg::GAIN_W-1:0];
        masa_pkg::CFG_GAIN_Y:   gain_y_q   <= cfg_wdata_i[masa_pkg::GAIN_W-1:0];
        masa_pkg::CFG_DEADZONE: deadzone_q <= cfg_wdata_i[masa_pkg::LEVEL_W-1:0];
        masa_pkg::CFG_SNAP:     snap_q     <= cfg_wdata_i[masa_pkg::LEVEL_W-1:0];
        masa_pkg::CFG_DIRECT:   direct_q   <= cfg_wdata_i[0];
        masa_pkg::CFG_HOOK:     hook_q     <= cfg_wdata_i[0];
        masa_pkg::CFG_CARRY:    carry_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign adv2            = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || adv2;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_blocked_q   <= s_axis_tuser_i[0] || !s_axis_tuser_i[1];
      s1_has_delta_q <= (s_axis_tdata_i[15:0] != '0) || (s_axis_tdata_i[31:16] != '0);
    end
  end

  masa_lane u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .commit_i   (adv2),
    .delta_i    ($signed(s_axis_tdata_i[15:0])),
    .gain_i     (gain_x_q),
    .direct_i   (direct_q),
    .deadzone_i (deadzone_q),
    .snap_i     (snap_q),
    .ctl_i      (ctl),
    .info_o     (info_x)
  );

  masa_lane u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .commit_i   (adv2),
    .delta_i    ($signed(s_axis_tdata_i[31:16])),
    .gain_i     (gain_y_q),
    .direct_i   (direct_q),
    .deadzone_i (deadzone_q),
    .snap_i     (snap_q),
    .ctl_i      (ctl),
    .info_o     (info_y)
  );

  always_comb begin
    idle    = !s1_has_delta_q && info_x.res_zero && info_y.res_zero;
    dz_hold = !direct_q && info_x.below_dz && info_y.below_dz;
    emit    = !s1_blocked_q && !idle && !dz_hold && (info_x.step_nz || info_y.step_nz);

    ctl.sat       = s1_has_delta_q;
    ctl.clear     = s1_blocked_q || (emit && !carry_q);
    ctl.take_step = emit;
  end

  always_comb begin
    if (emit) begin
      aim_x_d = info_x.step;
      aim_y_d = info_y.step;
      if (direct_q && hook_q) begin
        dest_d = masa_pkg::DEST_HOOK;
      end else begin
        dest_d = masa_pkg::DEST_MEM;
      end
    end else begin
      aim_x_d = '0;
      aim_y_d = '0;
      dest_d  = masa_pkg::DEST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv2) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      aim_x_q <= aim_x_d;
      aim_y_q <= aim_y_d;
      dest_q  <= dest_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {aim_y_q, aim_x_q};
  assign m_axis_tuser_o  = dest_q;

  `MASA_ASSERT_NEVER(a_silent_zero, m_valid_q && dest_q == masa_pkg::DEST_NONE && (aim_x_q != '0 || aim_y_q != '0), "silent result carries a step")
  `MASA_ASSERT(a_hook_direct, m_valid_q && dest_q == masa_pkg::DEST_HOOK |-> direct_q, "hook result outside direct mode")
  `MASA_ASSERT(a_accept_fills, in_accept |=> s1_valid_q, "accepted poll lost before product stage")
  `MASA_ASSERT(a_stage_hold, s1_valid_q && !adv2 |=> s1_valid_q, "stalled poll dropped from product stage")

endmodule

@@ test/mouse_aim_subpixel_accumulator_tb.sv @@
`timescale 1ns / 1ps

module mouse_aim_subpixel_accumulator_tb;
  import masa_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [STEP_W-1:0] ax;
    logic signed [STEP_W-1:0] ay;
    dest_e                    dest;
  } aim_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [31:0]       s_axis_tdata_i = '0;  // delta_x, delta_y
  logic [1:0]        s_axis_tuser_i = '0;  // suspend, focused
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [31:0]       m_axis_tdata_o;       // aim_x, aim_y
  logic [1:0]        m_axis_tuser_o;       // destination
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  mouse_aim_subpixel_accumulator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Mirror of the block's configuration and residuals
  logic [GAIN_W-1:0]  gain_x_r  = GAIN_RESET;
  logic [GAIN_W-1:0]  gain_y_r  = GAIN_RESET;
  logic [LEVEL_W-1:0] dz_r      = '0;
  logic [LEVEL_W-1:0] snap_r    = '0;
  logic               direct_r  = 1'b0;
  logic               hook_r    = 1'b0;
  logic               carry_r   = 1'b1;
  longint             res_x     = 0;
  longint             res_y     = 0;

  aim_t aim_q[$];
  aim_t want;
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint wrap16(longint v);
    logic signed [STEP_W-1:0] t;
    t = v[STEP_W-1:0];
    return t;
  endfunction

  function automatic longint clamp_res(longint v);
    if (v > longint'(RES_LIMIT)) return longint'(RES_LIMIT);
    if (v < -longint'(RES_LIMIT)) return -longint'(RES_LIMIT);
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint legacy_step(longint r);
    if (mag(r) >= longint'(snap_r)) return wrap16(r >>> FRAC_SHIFT);
    if (mag(r) >= longint'(dz_r)) return (r < 0) ? -1 : 1;
    return 0;
  endfunction

  function automatic aim_t predict_aim(logic signed [DELTA_W-1:0] dx,
                                       logic signed [DELTA_W-1:0] dy,
                                       logic sus, logic foc);
    longint rx, ry, ox, oy;
    aim_t   r;
    r  = '{ax: '0, ay: '0, dest: DEST_NONE};
    rx = res_x;
    ry = res_y;
    if (sus || !foc) begin
      res_x = 0;
      res_y = 0;
      return r;
    end
    if (dx != 0 || dy != 0) begin
      rx = clamp_res(rx + longint'(dx) * longint'(gain_x_r));
      ry = clamp_res(ry + longint'(dy) * longint'(gain_y_r));
    end else if (rx == 0 && ry == 0) begin
      return r;
    end
    if (direct_r) begin
      ox = wrap16(rx >>> DIRECT_SHIFT);
      oy = wrap16(ry >>> DIRECT_SHIFT);
      rx -= ox <<< DIRECT_SHIFT;
      ry -= oy <<< DIRECT_SHIFT;
      r.dest = hook_r ? DEST_HOOK : DEST_MEM;
    end else begin
      if (mag(rx) < longint'(dz_r) && mag(ry) < longint'(dz_r)) begin
        res_x = rx;
        res_y = ry;
        return r;
      end
      ox = legacy_step(rx);
      oy = legacy_step(ry);
      rx -= ox <<< FRAC_SHIFT;
      ry -= oy <<< FRAC_SHIFT;
      r.dest = DEST_MEM;
    end
    if (ox == 0 && oy == 0) begin
      res_x = rx;
      res_y = ry;
      r.dest = DEST_NONE;
      return r;
    end
    if (!carry_r) begin
      rx = 0;
      ry = 0;
    end
    res_x = rx;
    res_y = ry;
    r.ax = ox[STEP_W-1:0];
    r.ay = oy[STEP_W-1:0];
    return r;
  endfunction

  task automatic send_poll(input logic signed [DELTA_W-1:0] dx,
                           input logic signed [DELTA_W-1:0] dy,
                           input logic sus, input logic foc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {dy, dx};
    s_axis_tuser_i  <= {foc, sus};
    do @(posedge clk_i); while (!s_axis_tready_o);
    aim_q.push_back(predict_aim(dx, dy, sus, foc));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (aim_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_GAIN_X:   gain_x_r = val[GAIN_W-1:0];
      CFG_GAIN_Y:   gain_y_r = val[GAIN_W-1:0];
      CFG_DEADZONE: dz_r     = val[LEVEL_W-1:0];
      CFG_SNAP:     snap_r   = val[LEVEL_W-1:0];
      CFG_DIRECT:   direct_r = val[0];
      CFG_HOOK:     hook_r   = val[0];
      CFG_CARRY:    carry_r  = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic note_mismatch(input string field, input longint exp_v, input longint act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, act_v);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (aim_q.size() == 0) begin
        note_mismatch("unexpected transaction", 0, longint'(m_axis_tdata_o));
      end else begin
        want = aim_q.pop_front();
        if (m_axis_tdata_o[15:0] !== want.ax)
          note_mismatch("aim_x", want.ax, $signed(m_axis_tdata_o[15:0]));
        if (m_axis_tdata_o[31:16] !== want.ay)
          note_mismatch("aim_y", want.ay, $signed(m_axis_tdata_o[31:16]));
        if (m_axis_tuser_o !== want.dest)
          note_mismatch("destination", want.dest, m_axis_tuser_o);
      end
    end
  end

  // Result sink with random back-pressure
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("mouse_aim_subpixel_accumulator_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [DELTA_W-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2, 3, 4: return 16'(int'($urandom_range(0, 64)) - 32);
      5, 6:    return 16'(int'($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(24'hFFFFFF);
      2:       return CFG_W'(GAIN_RESET);
      3:       return CFG_W'($urandom_range(1, 65535));
      default: return CFG_W'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(RES_LIMIT);
      2, 3:    return CFG_W'($urandom_range(0, 1 << 16));
      4:       return CFG_W'($urandom_range(0, 1 << 22));
      default: return CFG_W'($urandom_range(0, RES_LIMIT));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_poll(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_poll(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    send_poll(16'sd1, -16'sd1, 1'b1, 1'b1);
    send_poll(16'sd5, 16'sd5, 1'b0, 1'b0);
    send_poll(-16'sd1, 16'sd1, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_direct_path();
    write_reg(CFG_DIRECT, CFG_W'(1));
    write_reg(CFG_HOOK, CFG_W'(1));
    write_reg(CFG_CARRY, CFG_W'(0));
    write_reg(CFG_GAIN_X, CFG_W'(24'hFFFFFF));
    write_reg(CFG_GAIN_Y, CFG_W'(0));
    // saturate, then a step that wraps beyond 16 bits
    send_poll(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_poll(16'sd1, 16'sh7fff, 1'b0, 1'b1);
    drain();
    write_reg(CFG_HOOK, CFG_W'(0));
    write_reg(CFG_CARRY, CFG_W'(1));
    write_reg(CFG_GAIN_Y, CFG_W'(GAIN_RESET));
    send_poll(16'sd3, -16'sd3, 1'b0, 1'b1);
    send_poll(16'sd0, 16'sd0, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_legacy_bands();
    write_reg(CFG_DIRECT, CFG_W'(0));
    write_reg(CFG_GAIN_X, CFG_W'(1));
    write_reg(CFG_GAIN_Y, CFG_W'(1));
    write_reg(CFG_DEADZONE, CFG_W'(8192));
    write_reg(CFG_SNAP, CFG_W'(1 << 20));
    send_poll(16'sd0, 16'sd0, 1'b1, 1'b1);
    send_poll(16'sd100, -16'sd200, 1'b0, 1'b1);
    send_poll(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_poll(16'sd8000, 16'sd0, 1'b0, 1'b1);
    send_poll(16'sd100, 16'sd0, 1'b0, 1'b1);
    drain();
    // zero residual outside the deadzone steps positive
    write_reg(CFG_DEADZONE, CFG_W'(0));
    write_reg(CFG_GAIN_X, CFG_W'(GAIN_RESET));
    send_poll(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_poll(16'sd100, 16'sd0, 1'b0, 1'b1);
    drain();
    // step wraps to 16 bits before it is consumed
    write_reg(CFG_SNAP, CFG_W'(0));
    write_reg(CFG_GAIN_X, CFG_W'(32768));
    send_poll(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_poll(16'sh7fff, 16'sd0, 1'b0, 1'b1);
    send_poll(16'sd0, 16'sd0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_DEADZONE, CFG_W'(RES_LIMIT));
    write_reg(CFG_SNAP, CFG_W'(RES_LIMIT));
    write_reg(CFG_GAIN_X, CFG_W'(24'hFFFFFF));
    write_reg(CFG_GAIN_Y, CFG_W'(24'hFFFFFF));
    write_reg(CFG_CARRY, CFG_W'(0));
    send_poll(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_poll(-16'sd1, -16'sd1, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(input int n_polls);
    logic sus, foc;
    write_reg(CFG_GAIN_X, rand_gain());
    write_reg(CFG_GAIN_Y, rand_gain());
    write_reg(CFG_DEADZONE, rand_level());
    write_reg(CFG_SNAP, rand_level());
    write_reg(CFG_DIRECT, CFG_W'($urandom_range(0, 1)));
    write_reg(CFG_HOOK, CFG_W'($urandom_range(0, 1)));
    write_reg(CFG_CARRY, CFG_W'($urandom_range(0, 1)));
    for (int i = 0; i < n_polls; i++) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      sus = ($urandom_range(0, 15) == 0);
      foc = ($urandom_range(0, 15) != 0);
      send_poll(rand_delta(), rand_delta(), sus, foc);
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_direct_path();
    test_legacy_bands();
    repeat (6) test_random_traffic(300);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && aim_q.size() == 0) begin
      $display("mouse_aim_subpixel_accumulator_tb: PASS");
    end else begin
      $display("mouse_aim_subpixel_accumulator_tb: FAIL");
    end
    $finish;
  end

endmodule
